[rtl/core/dbc_pkg.sv]
// dbc_pkg: widths, codes, control struct and helpers for the detection box clusterer
// used by dbc_mul, dbc_seq and detection_box_clusterer; no dependencies

package dbc_pkg;

  localparam int unsigned MaxClusters = 16;
  localparam int unsigned CoordBits   = 12;
  localparam int unsigned CountBits   = 8;

  localparam int unsigned LimBits      = 12;
  localparam int unsigned IdxBits      = (MaxClusters > 1) ? $clog2(MaxClusters) : 1;
  localparam int unsigned UsedBits     = IdxBits + 1;
  localparam int unsigned Cx2Bits      = CoordBits + 2;
  localparam int unsigned CsumBits     = CoordBits + 1 + CountBits;
  localparam int unsigned DsumBits     = CoordBits + CountBits;
  localparam int unsigned DlimBits     = LimBits + CountBits + 1;
  localparam int unsigned MulBits      = (CsumBits + 1 > DlimBits) ? CsumBits + 1 : DlimBits;
  localparam int unsigned ProdBits     = 2 * MulBits;
  localparam int unsigned OutIdxBits   = 4;
  localparam int unsigned OutCountBits = 8;
  localparam int unsigned StatusBits   = 2;

  localparam logic [CountBits-1:0] CountMax    = {CountBits{1'b1}};
  localparam logic [LimBits-1:0]   DistLimitRst = LimBits'(100);
  localparam logic [LimBits-1:0]   DimLimitRst  = LimBits'(50);

  typedef enum logic [0:0] {
    REG_DIST_LIMIT = 1'b0,
    REG_DIM_LIMIT  = 1'b1
  } reg_idx_e;

  typedef enum logic [StatusBits-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_SAT  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_MX, ST_MY, ST_MW, ST_MH, ST_MD, ST_ML,
    ST_SX, ST_SY, ST_DD, ST_CMP, ST_JOIN, ST_OPEN, ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_NX, MUL_NY, MUL_NW, MUL_NH, MUL_DIST, MUL_DIM,
    MUL_EX, MUL_EY, MUL_DD
  } mul_sel_e;

  typedef enum logic [3:0] {
    CAP_NONE, CAP_EX, CAP_EY, CAP_EW, CAP_EH, CAP_DLIM, CAP_MLIM,
    CAP_SQ, CAP_SQADD
  } cap_e;

  typedef enum logic [2:0] {
    RES_NONE, RES_CLEAR, RES_JOIN, RES_OPEN, RES_FULL
  } res_e;

  typedef struct packed {
    logic [CsumBits-1:0]  sum_x2;
    logic [CsumBits-1:0]  sum_y2;
    logic [DsumBits-1:0]  sum_w;
    logic [DsumBits-1:0]  sum_h;
    logic [CountBits-1:0] members;
  } entry_t;

  typedef struct packed {
    logic                rd_en;
    logic [IdxBits-1:0]  addr;
    logic [UsedBits-1:0] index;
    mul_sel_e            mul_sel;
    cap_e                cap;
    res_e                res;
    logic                out_load;
  } ctrl_t;

  function automatic logic [MulBits-1:0] abs_diff(input logic [MulBits-1:0] a,
                                                  input logic [MulBits-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

[rtl/core/dbc_ram.sv]
// dbc_ram: generic single write port, single read port ram with registered read
// no dependencies

module dbc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/dbc_mul.sv]
// dbc_mul: the shared unsigned multiplier with registered product
// depends on dbc_pkg for operand widths

module dbc_mul (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [dbc_pkg::MulBits-1:0]    a_i,
  input  logic [dbc_pkg::MulBits-1:0]    b_i,
  output logic [dbc_pkg::ProdBits-1:0]   prod_o
);

  logic [dbc_pkg::ProdBits-1:0] prod_d, prod_q;

  assign prod_d = dbc_pkg::ProdBits'(a_i) * dbc_pkg::ProdBits'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

[rtl/core/dbc_seq.sv]
// dbc_seq: sequencer that walks the cluster table and steps the shared multiplier
// depends on dbc_pkg for state, control struct and widths

module dbc_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  mode_i,
  input  logic                  match_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  output logic                  in_ready_o,
  output dbc_pkg::ctrl_t        ctrl_o
);

  dbc_pkg::state_e state_q, state_d;
  logic [dbc_pkg::IdxBits-1:0]  k_q, k_d;
  logic [dbc_pkg::UsedBits-1:0] used_q, used_d;
  logic                         accept;
  logic                         last_k;
  logic                         table_full;

  assign accept     = in_valid_i && (state_q == dbc_pkg::ST_IDLE);
  assign last_k     = (dbc_pkg::UsedBits'(k_q) + 1'b1) == used_q;
  assign table_full = used_q >= dbc_pkg::UsedBits'(dbc_pkg::MaxClusters);

  // next state and counters
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    used_d  = used_q;
    case (state_q)
      dbc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          k_d = '0;
          if (mode_i) begin
            used_d  = '0;
            state_d = dbc_pkg::ST_DONE;
          end else if (used_q == '0) begin
            state_d = dbc_pkg::ST_OPEN;
          end else begin
            state_d = dbc_pkg::ST_READ;
          end
        end
      end
      dbc_pkg::ST_READ: state_d = dbc_pkg::ST_MX;
      dbc_pkg::ST_MX:   state_d = dbc_pkg::ST_MY;
      dbc_pkg::ST_MY:   state_d = dbc_pkg::ST_MW;
      dbc_pkg::ST_MW:   state_d = dbc_pkg::ST_MH;
      dbc_pkg::ST_MH:   state_d = dbc_pkg::ST_MD;
      dbc_pkg::ST_MD:   state_d = dbc_pkg::ST_ML;
      dbc_pkg::ST_ML:   state_d = dbc_pkg::ST_SX;
      dbc_pkg::ST_SX:   state_d = dbc_pkg::ST_SY;
      dbc_pkg::ST_SY:   state_d = dbc_pkg::ST_DD;
      dbc_pkg::ST_DD:   state_d = dbc_pkg::ST_CMP;
      dbc_pkg::ST_CMP: begin
        if (match_i) begin
          state_d = dbc_pkg::ST_JOIN;
        end else if (last_k) begin
          state_d = dbc_pkg::ST_OPEN;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = dbc_pkg::ST_READ;
        end
      end
      dbc_pkg::ST_JOIN: state_d = dbc_pkg::ST_DONE;
      dbc_pkg::ST_OPEN: begin
        if (!table_full) begin
          used_d = used_q + 1'b1;
        end
        state_d = dbc_pkg::ST_DONE;
      end
      dbc_pkg::ST_DONE: begin
        if (!out_valid_i || out_ready_i) begin
          state_d = dbc_pkg::ST_IDLE;
        end
      end
      default: state_d = dbc_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctrl_o          = '0;
    ctrl_o.mul_sel  = dbc_pkg::MUL_NONE;
    ctrl_o.cap      = dbc_pkg::CAP_NONE;
    ctrl_o.res      = dbc_pkg::RES_NONE;
    ctrl_o.addr     = k_q;
    ctrl_o.index    = dbc_pkg::UsedBits'(k_q);
    case (state_q)
      dbc_pkg::ST_IDLE: begin
        if (accept && mode_i) begin
          ctrl_o.res = dbc_pkg::RES_CLEAR;
        end
      end
      dbc_pkg::ST_READ: ctrl_o.rd_en = 1'b1;
      dbc_pkg::ST_MX:   ctrl_o.mul_sel = dbc_pkg::MUL_NX;
      dbc_pkg::ST_MY: begin
        ctrl_o.mul_sel = dbc_pkg::MUL_NY;
        ctrl_o.cap     = dbc_pkg::CAP_EX;
      end
      dbc_pkg::ST_MW: begin
        ctrl_o.mul_sel = dbc_pkg::MUL_NW;
        ctrl_o.cap     = dbc_pkg::CAP_EY;
      end
      dbc_pkg::ST_MH: begin
        ctrl_o.mul_sel = dbc_pkg::MUL_NH;
        ctrl_o.cap     = dbc_pkg::CAP_EW;
      end
      dbc_pkg::ST_MD: begin
        ctrl_o.mul_sel = dbc_pkg::MUL_DIST;
        ctrl_o.cap     = dbc_pkg::CAP_EH;
      end
      dbc_pkg::ST_ML: begin
        ctrl_o.mul_sel = dbc_pkg::MUL_DIM;
        ctrl_o.cap     = dbc_pkg::CAP_DLIM;
      end
      dbc_pkg::ST_SX: begin
        ctrl_o.mul_sel = dbc_pkg::MUL_EX;
        ctrl_o.cap     = dbc_pkg::CAP_MLIM;
      end
      dbc_pkg::ST_SY: begin
        ctrl_o.mul_sel = dbc_pkg::MUL_EY;
        ctrl_o.cap     = dbc_pkg::CAP_SQ;
      end
      dbc_pkg::ST_DD: begin
        ctrl_o.mul_sel = dbc_pkg::MUL_DD;
        ctrl_o.cap     = dbc_pkg::CAP_SQADD;
      end
      dbc_pkg::ST_JOIN: ctrl_o.res = dbc_pkg::RES_JOIN;
      dbc_pkg::ST_OPEN: begin
        ctrl_o.addr  = used_q[dbc_pkg::IdxBits-1:0];
        ctrl_o.index = used_q;
        ctrl_o.res   = table_full ? dbc_pkg::RES_FULL : dbc_pkg::RES_OPEN;
      end
      dbc_pkg::ST_DONE: ctrl_o.out_load = !out_valid_i || out_ready_i;
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == dbc_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dbc_pkg::ST_IDLE;
      k_q     <= '0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      used_q  <= used_d;
    end
  end

  a_k_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dbc_pkg::ST_CMP) |-> (dbc_pkg::UsedBits'(k_q) < used_q))
    else $error("cluster walk ran past the used entries");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i) |=> (used_q == '0))
    else $error("clear request did not empty the table");

  a_open_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dbc_pkg::ST_OPEN && !table_full)
      |=> (used_q == dbc_pkg::UsedBits'($past(used_q) + 1'b1)))
    else $error("opening a cluster did not bump the used count");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= dbc_pkg::UsedBits'(dbc_pkg::MaxClusters))
    else $error("used count beyond table size");

endmodule

[rtl/core/detection_box_clusterer.sv]
// detection_box_clusterer: top level with box registers, match datapath and cluster table
// depends on dbc_pkg, dbc_ram, dbc_mul and dbc_seq

// Groups boxes into up to 16 clusters held in a small ram. A box request is
// compared against the used clusters in creation order, one cluster at a time,
// with a single shared multiplier that forms the scaled box center and size,
// the two limits and the squared distance in turn; the comparison stops at the
// first matching cluster, or covers all used ones when none matches. The block
// takes no new request until the current one has placed its result in the
// output register; a result that is still waiting there does not hold back the
// next request's work, only its final load. The user must write the limits
// through the cfg port only while the block is idle; the block itself does not
// enforce this.

module detection_box_clusterer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,    // 0 dist_limit, 1 dim_limit
  input  logic [11:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // box_x, box_y, box_width, box_height
  input  logic        s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // cluster_index, new_cluster, member_count, status, pad
);

  localparam int unsigned CB = dbc_pkg::CoordBits;
  localparam int unsigned MB = dbc_pkg::MulBits;
  localparam int unsigned PB = dbc_pkg::ProdBits;

  dbc_pkg::ctrl_t ctrl;
  dbc_pkg::entry_t entry, wr_entry;

  logic [dbc_pkg::LimBits-1:0] dist_q, dim_q;
  logic [dbc_pkg::Cx2Bits-1:0] cx2_q, cy2_q;
  logic [CB-1:0]               w_q, h_q;
  logic [CB-1:0]               in_x, in_y, in_w, in_h;

  logic [MB-1:0] ex_q, ey_q, ew_q, eh_q, dlim_q, mlim_q;
  logic [PB:0]   sq_q;
  logic [MB-1:0] mul_a, mul_b, prod_lo;
  logic [PB-1:0] prod;
  logic          match;
  logic          we;
  logic          can_add;

  logic [dbc_pkg::OutIdxBits-1:0]   res_idx_q;
  logic                             res_new_q;
  logic [dbc_pkg::OutCountBits-1:0] res_cnt_q;
  dbc_pkg::status_e                 res_stat_q;
  logic [dbc_pkg::CountBits-1:0]    cnt_next;

  logic        out_valid_q, out_valid_d;
  logic [15:0] out_data_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= dbc_pkg::DistLimitRst;
      dim_q  <= dbc_pkg::DimLimitRst;
    end else if (cfg_we_i) begin
      case (dbc_pkg::reg_idx_e'(cfg_addr_i))
        dbc_pkg::REG_DIST_LIMIT: dist_q <= cfg_wdata_i;
        dbc_pkg::REG_DIM_LIMIT:  dim_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_x = s_axis_tdata[CB-1:0];
  assign in_y = s_axis_tdata[12 +: CB];
  assign in_w = s_axis_tdata[24 +: CB];
  assign in_h = s_axis_tdata[36 +: CB];

  // box registers, centers kept doubled
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cx2_q <= dbc_pkg::Cx2Bits'({in_x, 1'b0}) + dbc_pkg::Cx2Bits'(in_w);
      cy2_q <= dbc_pkg::Cx2Bits'({in_y, 1'b0}) + dbc_pkg::Cx2Bits'(in_h);
      w_q   <= in_w;
      h_q   <= in_h;
    end
  end

  dbc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .mode_i      (s_axis_tuser),
    .match_i     (match),
    .out_valid_i (out_valid_q),
    .out_ready_i (m_axis_tready),
    .in_ready_o  (s_axis_tready),
    .ctrl_o      (ctrl)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul_sel)
      dbc_pkg::MUL_NX: begin
        mul_a = MB'(entry.members);
        mul_b = MB'(cx2_q);
      end
      dbc_pkg::MUL_NY: begin
        mul_a = MB'(entry.members);
        mul_b = MB'(cy2_q);
      end
      dbc_pkg::MUL_NW: begin
        mul_a = MB'(entry.members);
        mul_b = MB'(w_q);
      end
      dbc_pkg::MUL_NH: begin
        mul_a = MB'(entry.members);
        mul_b = MB'(h_q);
      end
      dbc_pkg::MUL_DIST: begin
        mul_a = MB'(entry.members);
        mul_b = MB'(dist_q);
      end
      dbc_pkg::MUL_DIM: begin
        mul_a = MB'(entry.members);
        mul_b = MB'(dim_q);
      end
      dbc_pkg::MUL_EX: begin
        mul_a = ex_q;
        mul_b = ex_q;
      end
      dbc_pkg::MUL_EY: begin
        mul_a = ey_q;
        mul_b = ey_q;
      end
      dbc_pkg::MUL_DD: begin
        mul_a = dlim_q;
        mul_b = dlim_q;
      end
      default: ;
    endcase
  end

  dbc_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (ctrl.mul_sel != dbc_pkg::MUL_NONE),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign prod_lo = prod[MB-1:0];

  // capture of the previous product
  always_ff @(posedge clk_i) begin
    case (ctrl.cap)
      dbc_pkg::CAP_EX:    ex_q   <= dbc_pkg::abs_diff(MB'(entry.sum_x2), prod_lo);
      dbc_pkg::CAP_EY:    ey_q   <= dbc_pkg::abs_diff(MB'(entry.sum_y2), prod_lo);
      dbc_pkg::CAP_EW:    ew_q   <= dbc_pkg::abs_diff(MB'(entry.sum_w), prod_lo);
      dbc_pkg::CAP_EH:    eh_q   <= dbc_pkg::abs_diff(MB'(entry.sum_h), prod_lo);
      dbc_pkg::CAP_DLIM:  dlim_q <= prod_lo << 1;
      dbc_pkg::CAP_MLIM:  mlim_q <= prod_lo;
      dbc_pkg::CAP_SQ:    sq_q   <= (PB + 1)'(prod);
      dbc_pkg::CAP_SQADD: sq_q   <= sq_q + (PB + 1)'(prod);
      default: ;
    endcase
  end

  // product now holds the squared distance limit
  assign match = (ex_q < dlim_q) && (ey_q < dlim_q) && (sq_q < (PB + 1)'(prod))
              && (ew_q < mlim_q) && (eh_q < mlim_q);

  assign can_add = (entry.members != dbc_pkg::CountMax);

  always_comb begin
    wr_entry = entry;
    we       = 1'b0;
    cnt_next = entry.members;
    case (ctrl.res)
      dbc_pkg::RES_JOIN: begin
        we = can_add;
        if (can_add) begin
          cnt_next = entry.members + 1'b1;
        end
        wr_entry.sum_x2  = entry.sum_x2 + dbc_pkg::CsumBits'(cx2_q);
        wr_entry.sum_y2  = entry.sum_y2 + dbc_pkg::CsumBits'(cy2_q);
        wr_entry.sum_w   = entry.sum_w + dbc_pkg::DsumBits'(w_q);
        wr_entry.sum_h   = entry.sum_h + dbc_pkg::DsumBits'(h_q);
        wr_entry.members = cnt_next;
      end
      dbc_pkg::RES_OPEN: begin
        we               = 1'b1;
        cnt_next         = dbc_pkg::CountBits'(1);
        wr_entry.sum_x2  = dbc_pkg::CsumBits'(cx2_q);
        wr_entry.sum_y2  = dbc_pkg::CsumBits'(cy2_q);
        wr_entry.sum_w   = dbc_pkg::DsumBits'(w_q);
        wr_entry.sum_h   = dbc_pkg::DsumBits'(h_q);
        wr_entry.members = cnt_next;
      end
      default: ;
    endcase
  end

  dbc_ram #(
    .Width ($bits(dbc_pkg::entry_t)),
    .Depth (dbc_pkg::MaxClusters)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (ctrl.addr),
    .wdata_i (wr_entry),
    .re_i    (ctrl.rd_en),
    .raddr_i (ctrl.addr),
    .rdata_o (entry)
  );

  // result fields
  always_ff @(posedge clk_i) begin
    case (ctrl.res)
      dbc_pkg::RES_CLEAR, dbc_pkg::RES_FULL: begin
        res_idx_q  <= '0;
        res_new_q  <= 1'b0;
        res_cnt_q  <= '0;
        res_stat_q <= (ctrl.res == dbc_pkg::RES_FULL) ? dbc_pkg::STAT_FULL : dbc_pkg::STAT_OK;
      end
      dbc_pkg::RES_JOIN, dbc_pkg::RES_OPEN: begin
        res_idx_q  <= dbc_pkg::OutIdxBits'(ctrl.index);
        res_new_q  <= (ctrl.res == dbc_pkg::RES_OPEN);
        res_cnt_q  <= dbc_pkg::OutCountBits'(cnt_next);
        res_stat_q <= (cnt_next == dbc_pkg::CountMax) ? dbc_pkg::STAT_SAT : dbc_pkg::STAT_OK;
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_data_q <= {1'b0, res_stat_q, res_cnt_q, res_new_q, res_idx_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
